// ----- rtl/core/pse_pkg.sv -----
package pse_pkg;

  localparam int unsigned SIDE_W    = 15;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

  localparam logic [SIDE_W-1:0] MAX_SIDE = 15'd16384;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] ALL_ONES  = 32'hFFFFFFFF;
  localparam logic [16:0] ADLER_MOD = 17'd65521;
  localparam logic [15:0] BLOCK_MAX = 16'hFFFF;

  localparam logic [7:0] ZLIB_CMF   = 8'h78;
  localparam logic [7:0] ZLIB_FLG   = 8'h01;
  localparam logic [7:0] BIT_DEPTH  = 8'd8;
  localparam logic [7:0] COLOR_TYPE = 8'd2;

  localparam logic [31:0] IHDR_LEN = 32'd13;
  localparam logic [31:0] TAG_IHDR = 32'h49484452;
  localparam logic [31:0] TAG_IDAT = 32'h49444154;
  localparam logic [31:0] TAG_IEND = 32'h49454E44;

  localparam logic [7:0] PNG_SIG [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                         8'h0D, 8'h0A, 8'h1A, 8'h0A};

  typedef struct packed {
    logic [15:0] row_bytes;
    logic [29:0] raw_len;
    logic [31:0] idat_len;
  } size_info_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] k);
    logic [7:0] b;
    unique case (k)
      2'd0: b = w[31:24];
      2'd1: b = w[23:16];
      2'd2: b = w[15:8];
      2'd3: b = w[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [SIDE_W-1:0] side_clamp(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] s;
    if (v == '0) begin
      s = 15'd1;
    end else if (v > MAX_SIDE) begin
      s = MAX_SIDE;
    end else begin
      s = v;
    end
    return s;
  endfunction

endpackage

// ----- rtl/core/pse_size_calc.sv -----
module pse_size_calc (
  input  logic                          clk,
  input  logic [pse_pkg::SIDE_W-1:0]    width,
  input  logic [pse_pkg::SIDE_W-1:0]    height,
  output pse_pkg::size_info_t           size
);

  logic [15:0] row_bytes_r;
  logic [15:0] row_bytes_p1;
  logic [30:0] raw_prod;
  logic [29:0] raw_r;
  logic [29:0] raw_d_r;
  logic [16:0] rem0;
  logic [14:0] quot_nxt;
  logic [14:0] quot_r;
  logic [31:0] idat_nxt;
  logic [31:0] idat_r;

  // The raw length divided by 65535: the high half is the first guess, and the
  // remainder stays below twice the divisor, so one correction suffices.
  assign row_bytes_p1 = row_bytes_r + 16'd1;
  assign raw_prod     = {15'd0, row_bytes_p1} * {16'd0, height};
  assign rem0         = {1'b0, raw_r[15:0]} + {3'd0, raw_r[29:16]};
  assign quot_nxt     = {1'b0, raw_r[29:16]} + {14'd0, (rem0 >= 17'd65535)};
  assign idat_nxt     = {2'd0, raw_d_r} + {15'd0, quot_r, 2'b00} + {17'd0, quot_r} + 32'd11;

  always_ff @(posedge clk) begin
    row_bytes_r <= {1'b0, width} + {width, 1'b0};
    raw_r       <= raw_prod[29:0];
    raw_d_r     <= raw_r;
    quot_r      <= quot_nxt;
    idat_r      <= idat_nxt;
  end

  assign size.row_bytes = row_bytes_r;
  assign size.raw_len   = raw_r;
  assign size.idat_len  = idat_r;

endmodule

// ----- rtl/core/png_stored_block_encoder_top.sv -----
// PNG encoder with stored (uncompressed) DEFLATE blocks.
// Input channel: one pixel byte per request (R, G, B, rows top to bottom).
// Output channel: one byte of the PNG file per request; out_run_last marks the
// last byte caused by an input request and out_file_end the last byte of the file.
// Configuration: cfg_we writes image width (index 0) or height (index 1); a
// side of zero is taken as 1 and one above 16384 as 16384. A write starts a
// new file on the next input request. Write only while the encoder is idle.
// A request is held in a register and its first byte then goes to the output
// register. The encoder emits one byte per cycle while the receiver does not
// stall. A pixel inside a row emits its byte; one that starts a row adds a
// filter byte, the first pixel of a file the headers, one that fills a 65535-byte
// block a block header, the last of the file the Adler32, CRC and IEND trailer.
// Input requests are taken back to back while each causes a single byte.
// When the receiver stalls, the output register holds its byte and the
// encoder stops; the input then stalls as soon as the held request is busy.
// Reset sets width and height to 1 and leaves no file in progress. The size
// pipeline fills its registers after a configuration write, well before use.
module png_stored_block_encoder_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           in_pixel_byte,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [7:0]                           out_byte,
  output logic                                 out_run_last,
  output logic                                 out_file_end,
  input  logic                                 cfg_we,
  input  logic [pse_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pse_pkg::SIDE_W-1:0]           cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_FILT,
    S_PIX,
    S_BLK,
    S_TRL
  } state_t;

  localparam logic [5:0] HDR_LEN_AT     = 6'd8;
  localparam logic [5:0] HDR_IHDR_AT    = 6'd12;
  localparam logic [5:0] HDR_W_AT       = 6'd16;
  localparam logic [5:0] HDR_H_AT       = 6'd20;
  localparam logic [5:0] HDR_DEPTH_AT   = 6'd24;
  localparam logic [5:0] HDR_COLOR_AT   = 6'd25;
  localparam logic [5:0] HDR_CRC_AT     = 6'd29;
  localparam logic [5:0] HDR_IDATLEN_AT = 6'd33;
  localparam logic [5:0] HDR_IDAT_AT    = 6'd37;
  localparam logic [5:0] HDR_CMF_AT     = 6'd41;
  localparam logic [5:0] HDR_LAST       = 6'd42;
  localparam logic [5:0] BLK_LAST       = 6'd4;
  localparam logic [5:0] TRL_CRC_AT     = 6'd4;
  localparam logic [5:0] TRL_ZERO_AT    = 6'd8;
  localparam logic [5:0] TRL_IEND_AT    = 6'd12;
  localparam logic [5:0] TRL_END_CRC_AT = 6'd16;
  localparam logic [5:0] TRL_LAST       = 6'd19;

  state_t                       st_r, st_nxt, ret_r, ret_nxt;
  logic [5:0]                   idx_r, idx_nxt;
  logic                         item_valid_r, item_valid_nxt;
  logic [7:0]                   item_byte_r, item_byte_nxt;
  logic                         started_r, started_nxt;
  logic [15:0]                  col_r, col_nxt;
  logic [15:0]                  fill_r, fill_nxt;
  logic [29:0]                  raw_left_r, raw_left_nxt;
  logic [15:0]                  adler_lo_r, adler_lo_nxt;
  logic [15:0]                  adler_hi_r, adler_hi_nxt;
  logic [31:0]                  crc_r, crc_nxt;
  logic [pse_pkg::SIDE_W-1:0]   width_r, width_nxt;
  logic [pse_pkg::SIDE_W-1:0]   height_r, height_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [7:0]                   out_byte_r, out_byte_nxt;
  logic                         out_run_last_r, out_run_last_nxt;
  logic                         out_file_end_r, out_file_end_nxt;

  pse_pkg::size_info_t          size;

  logic                         advance;
  logic                         done;
  logic                         accept;
  logic [7:0]                   byte_v;
  logic                         crc_en;
  logic                         crc_init;
  logic                         raw_en;
  logic                         last_byte;
  logic                         file_done;
  logic                         hdr_start;
  logic                         raw_load;
  logic                         col_step;
  logic                         fill_clear;
  state_t                       go_st, go_ret;
  logic [15:0]                  fill_inc;
  logic [29:0]                  raw_dec;
  logic [15:0]                  col_inc;
  logic                         blk_final;
  logic [15:0]                  blk_len;
  logic [1:0]                   hdr_k;
  logic [16:0]                  lo_sum, hi_sum;
  logic [15:0]                  lo_new, hi_new;
  logic [31:0]                  crc_base;

  pse_size_calc u_size_calc (
    .clk    (clk),
    .width  (width_r),
    .height (height_r),
    .size   (size)
  );

  assign advance   = item_valid_r && (!out_valid_r || !out_stall);
  assign done      = advance && last_byte;
  assign in_stall  = item_valid_r && !done;
  assign accept    = in_valid && !in_stall;

  assign fill_inc  = fill_r + 16'd1;
  assign raw_dec   = raw_left_r - {29'd0, (raw_left_r != '0)};
  assign col_inc   = col_r + 16'd1;
  assign blk_final = raw_left_r < 30'd65535;
  assign blk_len   = blk_final ? raw_left_r[15:0] : pse_pkg::BLOCK_MAX;
  assign hdr_k     = idx_r[1:0] - 2'd1;

  // Adler32 sums stay below twice the modulus, so one subtraction reduces them.
  assign lo_sum = {1'b0, adler_lo_r} + {9'd0, byte_v};
  assign lo_new = (lo_sum >= pse_pkg::ADLER_MOD) ? 16'(lo_sum - pse_pkg::ADLER_MOD)
                                                 : lo_sum[15:0];
  assign hi_sum = {1'b0, adler_hi_r} + {1'b0, lo_new};
  assign hi_new = (hi_sum >= pse_pkg::ADLER_MOD) ? 16'(hi_sum - pse_pkg::ADLER_MOD)
                                                 : hi_sum[15:0];

  assign crc_base = crc_init ? pse_pkg::ALL_ONES : crc_r;

  // Decode of the byte that the current step emits and of where it goes next.
  always_comb begin
    byte_v     = 8'd0;
    crc_en     = 1'b0;
    crc_init   = 1'b0;
    raw_en     = 1'b0;
    last_byte  = 1'b0;
    file_done  = 1'b0;
    hdr_start  = 1'b0;
    raw_load   = 1'b0;
    col_step   = 1'b0;
    fill_clear = 1'b0;
    go_st      = st_r;
    go_ret     = ret_r;
    unique case (st_r)
      S_HDR: begin
        hdr_start = (idx_r == '0);
        raw_load  = (idx_r == HDR_LEN_AT);
        priority if (idx_r < HDR_LEN_AT) begin
          byte_v = pse_pkg::PNG_SIG[idx_r[2:0]];
        end else if (idx_r < HDR_IHDR_AT) begin
          byte_v = pse_pkg::word_byte(pse_pkg::IHDR_LEN, idx_r[1:0]);
        end else if (idx_r < HDR_W_AT) begin
          byte_v   = pse_pkg::word_byte(pse_pkg::TAG_IHDR, idx_r[1:0]);
          crc_en   = 1'b1;
          crc_init = (idx_r == HDR_IHDR_AT);
        end else if (idx_r < HDR_H_AT) begin
          byte_v = pse_pkg::word_byte({17'd0, width_r}, idx_r[1:0]);
          crc_en = 1'b1;
        end else if (idx_r < HDR_DEPTH_AT) begin
          byte_v = pse_pkg::word_byte({17'd0, height_r}, idx_r[1:0]);
          crc_en = 1'b1;
        end else if (idx_r == HDR_DEPTH_AT) begin
          byte_v = pse_pkg::BIT_DEPTH;
          crc_en = 1'b1;
        end else if (idx_r == HDR_COLOR_AT) begin
          byte_v = pse_pkg::COLOR_TYPE;
          crc_en = 1'b1;
        end else if (idx_r < HDR_CRC_AT) begin
          byte_v = 8'd0;
          crc_en = 1'b1;
        end else if (idx_r < HDR_IDATLEN_AT) begin
          byte_v = pse_pkg::word_byte(crc_r ^ pse_pkg::ALL_ONES, hdr_k);
        end else if (idx_r < HDR_IDAT_AT) begin
          byte_v = pse_pkg::word_byte(size.idat_len, hdr_k);
        end else if (idx_r < HDR_CMF_AT) begin
          byte_v   = pse_pkg::word_byte(pse_pkg::TAG_IDAT, hdr_k);
          crc_en   = 1'b1;
          crc_init = (idx_r == HDR_IDAT_AT);
        end else if (idx_r == HDR_CMF_AT) begin
          byte_v = pse_pkg::ZLIB_CMF;
          crc_en = 1'b1;
        end else begin
          byte_v = pse_pkg::ZLIB_FLG;
          crc_en = 1'b1;
        end
        if (idx_r == HDR_LAST) begin
          go_st  = S_BLK;
          go_ret = S_FILT;
        end
      end
      S_FILT: begin
        byte_v = 8'd0;
        crc_en = 1'b1;
        raw_en = 1'b1;
        if (fill_inc == pse_pkg::BLOCK_MAX) begin
          go_st  = S_BLK;
          go_ret = S_PIX;
        end else begin
          go_st = S_PIX;
        end
      end
      S_PIX: begin
        byte_v   = item_byte_r;
        crc_en   = 1'b1;
        raw_en   = 1'b1;
        col_step = 1'b1;
        if (fill_inc == pse_pkg::BLOCK_MAX) begin
          go_st  = S_BLK;
          go_ret = S_IDLE;
        end else if (raw_dec == '0) begin
          go_st = S_TRL;
        end else begin
          last_byte = 1'b1;
        end
      end
      S_BLK: begin
        crc_en = 1'b1;
        unique case (idx_r[2:0])
          3'd0:    byte_v = {7'd0, blk_final};
          3'd1:    byte_v = blk_len[7:0];
          3'd2:    byte_v = blk_len[15:8];
          3'd3:    byte_v = ~blk_len[7:0];
          default: byte_v = ~blk_len[15:8];
        endcase
        if (idx_r == BLK_LAST) begin
          fill_clear = 1'b1;
          if (ret_r == S_FILT || ret_r == S_PIX) begin
            go_st = ret_r;
          end else if (raw_left_r == '0) begin
            go_st = S_TRL;
          end else begin
            last_byte = 1'b1;
          end
        end
      end
      S_TRL: begin
        priority if (idx_r < TRL_CRC_AT) begin
          byte_v = pse_pkg::word_byte({adler_hi_r, adler_lo_r}, idx_r[1:0]);
          crc_en = 1'b1;
        end else if (idx_r < TRL_ZERO_AT) begin
          byte_v = pse_pkg::word_byte(crc_r ^ pse_pkg::ALL_ONES, idx_r[1:0]);
        end else if (idx_r < TRL_IEND_AT) begin
          byte_v = 8'd0;
        end else if (idx_r < TRL_END_CRC_AT) begin
          byte_v   = pse_pkg::word_byte(pse_pkg::TAG_IEND, idx_r[1:0]);
          crc_en   = 1'b1;
          crc_init = (idx_r == TRL_IEND_AT);
        end else begin
          byte_v = pse_pkg::word_byte(crc_r ^ pse_pkg::ALL_ONES, idx_r[1:0]);
        end
        if (idx_r == TRL_LAST) begin
          last_byte = 1'b1;
          file_done = 1'b1;
        end
      end
      default: begin
        byte_v = 8'd0;
      end
    endcase
  end

  always_comb begin
    st_nxt           = st_r;
    ret_nxt          = ret_r;
    idx_nxt          = idx_r;
    item_valid_nxt   = item_valid_r;
    item_byte_nxt    = item_byte_r;
    started_nxt      = started_r;
    col_nxt          = col_r;
    fill_nxt         = fill_r;
    raw_left_nxt     = raw_left_r;
    adler_lo_nxt     = adler_lo_r;
    adler_hi_nxt     = adler_hi_r;
    crc_nxt          = crc_r;
    width_nxt        = width_r;
    height_nxt       = height_r;
    out_valid_nxt    = out_valid_r;
    out_byte_nxt     = out_byte_r;
    out_run_last_nxt = out_run_last_r;
    out_file_end_nxt = out_file_end_r;

    if (advance) begin
      out_valid_nxt    = 1'b1;
      out_byte_nxt     = byte_v;
      out_run_last_nxt = last_byte;
      out_file_end_nxt = file_done;
      st_nxt           = go_st;
      ret_nxt          = go_ret;
      idx_nxt          = (go_st == st_r) ? idx_r + 6'd1 : 6'd0;
      if (hdr_start) begin
        started_nxt = 1'b1;
      end
      if (raw_load) begin
        raw_left_nxt = size.raw_len;
      end
      if (crc_en) begin
        crc_nxt = pse_pkg::crc_byte(crc_base, byte_v);
      end
      if (raw_en) begin
        adler_lo_nxt = lo_new;
        adler_hi_nxt = hi_new;
        raw_left_nxt = raw_dec;
        fill_nxt     = fill_inc;
      end
      if (fill_clear) begin
        fill_nxt = '0;
      end
      if (col_step) begin
        col_nxt = (col_inc >= size.row_bytes) ? 16'd0 : col_inc;
      end
      if (file_done) begin
        started_nxt  = 1'b0;
        col_nxt      = '0;
        fill_nxt     = '0;
        raw_left_nxt = '0;
        adler_lo_nxt = 16'd1;
        adler_hi_nxt = '0;
        crc_nxt      = pse_pkg::ALL_ONES;
      end
      if (last_byte) begin
        st_nxt         = S_IDLE;
        item_valid_nxt = 1'b0;
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      unique case (cfg_index)
        pse_pkg::CFG_WIDTH:  width_nxt  = pse_pkg::side_clamp(cfg_wdata);
        pse_pkg::CFG_HEIGHT: height_nxt = pse_pkg::side_clamp(cfg_wdata);
      endcase
      started_nxt  = 1'b0;
      col_nxt      = '0;
      fill_nxt     = '0;
      raw_left_nxt = '0;
      adler_lo_nxt = 16'd1;
      adler_hi_nxt = '0;
      crc_nxt      = pse_pkg::ALL_ONES;
    end

    if (accept) begin
      item_valid_nxt = 1'b1;
      item_byte_nxt  = in_pixel_byte;
      idx_nxt        = '0;
      if (!started_nxt) begin
        st_nxt = S_HDR;
      end else if (col_nxt == '0) begin
        st_nxt = S_FILT;
      end else begin
        st_nxt = S_PIX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r           <= S_IDLE;
      ret_r          <= S_IDLE;
      idx_r          <= '0;
      item_valid_r   <= 1'b0;
      started_r      <= 1'b0;
      col_r          <= '0;
      fill_r         <= '0;
      raw_left_r     <= '0;
      adler_lo_r     <= 16'd1;
      adler_hi_r     <= '0;
      crc_r          <= pse_pkg::ALL_ONES;
      width_r        <= 15'd1;
      height_r       <= 15'd1;
      out_valid_r    <= 1'b0;
    end else begin
      st_r           <= st_nxt;
      ret_r          <= ret_nxt;
      idx_r          <= idx_nxt;
      item_valid_r   <= item_valid_nxt;
      started_r      <= started_nxt;
      col_r          <= col_nxt;
      fill_r         <= fill_nxt;
      raw_left_r     <= raw_left_nxt;
      adler_lo_r     <= adler_lo_nxt;
      adler_hi_r     <= adler_hi_nxt;
      crc_r          <= crc_nxt;
      width_r        <= width_nxt;
      height_r       <= height_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    item_byte_r    <= item_byte_nxt;
    out_byte_r     <= out_byte_nxt;
    out_run_last_r <= out_run_last_nxt;
    out_file_end_r <= out_file_end_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_run_last = out_run_last_r;
  assign out_file_end = out_file_end_r;

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_file_end |-> out_run_last)
    else $error("file end without run end");

  a_stall_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !item_valid_r |-> !in_stall)
    else $error("input stalled with no request held");

  a_block_opened: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid_r && st_r != S_BLK |-> fill_r != pse_pkg::BLOCK_MAX)
    else $error("full block not closed");

  a_new_file_header: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !item_valid_r && !started_r && !cfg_we |=> st_r == S_HDR)
    else $error("new file did not start with the header");

endmodule
